/* sv/mosl_pkg.sv */
// Package for the median-of-two-sorted-lists unit.
// Holds opcodes, field widths and the command/status types that join the
// controller and the datapath. Depends on nothing.
package mosl_pkg;

    // Payload widths.
    localparam int OP_W    = 2;
    localparam int DATA_W  = 32;
    localparam int MED_W   = 33;

    // Input opcodes.
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

    // Which value the datapath places in the result register.
    typedef enum logic [1:0] {
        RES_EMPTY  = 2'd0,
        RES_NONE   = 2'd1,
        RES_PAIR   = 2'd2,
        RES_SINGLE = 2'd3
    } t_res_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     wr_first;
        logic     wr_second;
        logic     capture;
        logic     setup;
        logic     calc_mid;
        logic     eval;
        logic     step;
        logic     load_res;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic both_empty;
        logic one_empty;
        logic lo_gt_hi;
        logic found;
    } t_dp_status;

endpackage

/* sv/mosl_if.sv */
// Channel interfaces for the median-of-two-sorted-lists unit.
// The input channel carries load and compute items, the output channel results.
// Depends on mosl_pkg for the payload widths.
interface mosl_in_if import mosl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mosl_out_if import mosl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MED_W-1:0] median_doubled;
    logic                    both_empty;
    logic                    overflowed;

    modport source (output valid, output median_doubled, output both_empty,
                    output overflowed, input ready);
    modport sink   (input valid, input median_doubled, input both_empty,
                    input overflowed, output ready);
endinterface

/* sv/mosl_ram.sv */
// Generic RAM: one write port and two read ports with registered read data.
// Used for both element lists. Depends on nothing.
module mosl_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports register their data.
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* sv/mosl_datapath.sv */
// Datapath of the median unit: the two list memories, fill counts, the
// binary partition search registers and the result register.
// Depends on mosl_pkg and mosl_ram.
module mosl_datapath import mosl_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic signed [DATA_W-1:0] i_value,
    output logic signed [MED_W-1:0]  o_median_doubled,
    output logic                     o_both_empty,
    output logic                     o_overflowed
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = CW + 1;

    // Fill state.
    logic [CW-1:0] r_cnt0, n_cnt0;
    logic [CW-1:0] r_cnt1, n_cnt1;
    logic          r_drop, n_drop;

    // Captured lengths and search state.
    logic [CW-1:0] r_len0, r_len1;
    logic          r_ovf;
    logic          r_swap, r_single;
    logic [CW-1:0] r_n, r_m, r_half;
    logic [LW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_mid, r_req;
    logic          r_ok1, r_ok2;
    logic signed [DATA_W-1:0] r_lmax, r_rmin;
    logic signed [MED_W-1:0]  r_med;
    logic                     r_empty;

    logic          w_full0, w_full1, w_we0, w_we1;
    logic          w_swap;
    logic [CW-1:0] w_n, w_m;
    logic [CW:0]   w_total;
    logic [LW:0]   w_lohi;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_base, w_base_m1, w_req_m1;
    logic [AW-1:0] w_s_addr_a, w_s_addr_b, w_t_addr_a, w_t_addr_b;
    logic [DATA_W-1:0] w_rd0_a, w_rd0_b, w_rd1_a, w_rd1_b;
    logic signed [DATA_W-1:0] w_s_a, w_s_b, w_t_a, w_t_b;
    logic          w_l1v, w_l2v, w_r1v, w_r2v, w_ok1, w_ok2;
    logic signed [DATA_W-1:0] w_lmax, w_rmin;
    logic signed [MED_W-1:0]  w_res;

    // Appends: a load to a full list is dropped and flagged.
    assign w_full0 = (r_cnt0 == CW'(DEPTH));
    assign w_full1 = (r_cnt1 == CW'(DEPTH));
    assign w_we0   = i_cmd.wr_first && !w_full0;
    assign w_we1   = i_cmd.wr_second && !w_full1;

    always_comb begin
        n_cnt0 = r_cnt0;
        n_cnt1 = r_cnt1;
        n_drop = r_drop;
        if (w_we0) begin
            n_cnt0 = r_cnt0 + CW'(1);
        end
        if (w_we1) begin
            n_cnt1 = r_cnt1 + CW'(1);
        end
        if ((i_cmd.wr_first && w_full0) || (i_cmd.wr_second && w_full1)) begin
            n_drop = 1'b1;
        end
        if (i_cmd.capture) begin
            n_cnt0 = '0;
            n_cnt1 = '0;
            n_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0 <= '0;
            r_cnt1 <= '0;
            r_drop <= 1'b0;
        end else begin
            r_cnt0 <= n_cnt0;
            r_cnt1 <= n_cnt1;
            r_drop <= n_drop;
        end
    end

    // The shorter list becomes the searched one; a lone non-empty list too.
    assign w_swap  = (r_len0 == '0) || ((r_len1 != '0) && (r_len0 > r_len1));
    assign w_n     = w_swap ? r_len1 : r_len0;
    assign w_m     = w_swap ? r_len0 : r_len1;
    assign w_total = {1'b0, w_n} + {1'b0, w_m} + (CW+1)'(1);

    // Midpoint of the current search window.
    assign w_lohi = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_lohi[CW:1];

    // Search and single-list registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_len0 <= r_cnt0;
            r_len1 <= r_cnt1;
            r_ovf  <= r_drop;
        end
        if (i_cmd.setup) begin
            r_swap   <= w_swap;
            r_single <= (w_m == '0);
            r_n      <= w_n;
            r_m      <= w_m;
            r_half   <= w_total[CW:1];
            r_lo     <= '0;
            r_hi     <= {1'b0, w_n};
        end
        if (i_cmd.calc_mid) begin
            r_mid <= w_mid;
            r_req <= r_half - w_mid;
        end
        if (i_cmd.eval) begin
            r_ok1  <= w_ok1;
            r_ok2  <= w_ok2;
            r_lmax <= w_lmax;
            r_rmin <= w_rmin;
        end
        if (i_cmd.step) begin
            if (!r_ok1) begin
                r_hi <= {1'b0, r_mid} - LW'(1);
            end else begin
                r_lo <= {1'b0, r_mid} + LW'(1);
            end
        end
    end

    // Read addresses: two neighbors in each list around the partition.
    assign w_base     = r_single ? (r_n >> 1) : r_mid;
    assign w_base_m1  = w_base - CW'(1);
    assign w_req_m1   = r_req - CW'(1);
    assign w_s_addr_a = w_base_m1[AW-1:0];
    assign w_s_addr_b = w_base[AW-1:0];
    assign w_t_addr_a = w_req_m1[AW-1:0];
    assign w_t_addr_b = r_req[AW-1:0];

    mosl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_first (
        .i_clk     (i_clk),
        .i_we      (w_we0),
        .i_waddr   (r_cnt0[AW-1:0]),
        .i_wdata   (i_value),
        .i_raddr_a (r_swap ? w_t_addr_a : w_s_addr_a),
        .o_rdata_a (w_rd0_a),
        .i_raddr_b (r_swap ? w_t_addr_b : w_s_addr_b),
        .o_rdata_b (w_rd0_b)
    );

    mosl_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_second (
        .i_clk     (i_clk),
        .i_we      (w_we1),
        .i_waddr   (r_cnt1[AW-1:0]),
        .i_wdata   (i_value),
        .i_raddr_a (r_swap ? w_s_addr_a : w_t_addr_a),
        .o_rdata_a (w_rd1_a),
        .i_raddr_b (r_swap ? w_s_addr_b : w_t_addr_b),
        .o_rdata_b (w_rd1_b)
    );

    assign w_s_a = r_swap ? w_rd1_a : w_rd0_a;
    assign w_s_b = r_swap ? w_rd1_b : w_rd0_b;
    assign w_t_a = r_swap ? w_rd0_a : w_rd1_a;
    assign w_t_b = r_swap ? w_rd0_b : w_rd1_b;

    // Partition check; the valid flags replace the infinite bounds at the ends.
    assign w_l1v = (r_mid != '0);
    assign w_l2v = (r_req != '0);
    assign w_r1v = (r_mid < r_n);
    assign w_r2v = (r_req < r_m);
    assign w_ok1 = !w_l1v || !w_r2v || (w_s_a <= w_t_b);
    assign w_ok2 = !w_l2v || !w_r1v || (w_t_a <= w_s_b);

    always_comb begin
        if (!w_l1v) begin
            w_lmax = w_t_a;
        end else if (!w_l2v) begin
            w_lmax = w_s_a;
        end else begin
            w_lmax = (w_s_a > w_t_a) ? w_s_a : w_t_a;
        end
        if (!w_r1v) begin
            w_rmin = w_t_b;
        end else if (!w_r2v) begin
            w_rmin = w_s_b;
        end else begin
            w_rmin = (w_s_b < w_t_b) ? w_s_b : w_t_b;
        end
    end

    // Twice the median, exact in 33 bits.
    always_comb begin
        case (i_cmd.res_sel)
            RES_PAIR: begin
                if (r_n[0] ^ r_m[0]) begin
                    w_res = {r_lmax, 1'b0};
                end else begin
                    w_res = MED_W'(r_lmax) + MED_W'(r_rmin);
                end
            end
            RES_SINGLE: begin
                if (r_n[0]) begin
                    w_res = {w_s_b, 1'b0};
                end else begin
                    w_res = MED_W'(w_s_a) + MED_W'(w_s_b);
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_res) begin
            r_med   <= w_res;
            r_empty <= (i_cmd.res_sel == RES_EMPTY);
        end
    end

    // Status toward the controller.
    assign o_status.both_empty = (r_len0 == '0) && (r_len1 == '0);
    assign o_status.one_empty  = (r_len0 == '0) != (r_len1 == '0);
    assign o_status.lo_gt_hi   = (r_lo > r_hi);
    assign o_status.found      = r_ok1 && r_ok2;

    assign o_median_doubled = r_med;
    assign o_both_empty     = r_empty;
    assign o_overflowed     = r_ovf;

endmodule

/* sv/mosl_ctrl.sv */
// Controller of the median unit: handshakes and the search sequencer.
// Issues commands to the datapath and reads back its status.
// Depends on mosl_pkg.
module mosl_ctrl import mosl_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_in_opcode,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_dp_cmd         o_cmd,
    input  t_dp_status      i_status
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SETUP  = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_READ   = 8'b0000_1000,
        ST_EVAL   = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_SREAD  = 8'b0100_0000,
        ST_SEVAL  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // A compute transaction waits until the result register is free.
    assign o_in_ready = (r_state == ST_IDLE) &&
                        ((i_in_opcode != OP_COMPUTE) || !r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_sel = RES_EMPTY;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_opcode)
                        OP_LOAD_FIRST: begin
                            o_cmd.wr_first = 1'b1;
                        end
                        OP_LOAD_SECOND: begin
                            o_cmd.wr_second = 1'b1;
                        end
                        OP_COMPUTE: begin
                            o_cmd.capture = 1'b1;
                            n_state = ST_SETUP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_status.both_empty) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_sel  = RES_EMPTY;
                    n_state = ST_IDLE;
                end else if (i_status.one_empty) begin
                    n_state = ST_SREAD;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.lo_gt_hi) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_sel  = RES_NONE;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.calc_mid = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_status.found) begin
                    o_cmd.load_res = 1'b1;
                    o_cmd.res_sel  = RES_PAIR;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_SREAD: begin
                n_state = ST_SEVAL;
            end
            ST_SEVAL: begin
                o_cmd.load_res = 1'b1;
                o_cmd.res_sel  = RES_SINGLE;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result valid flag: set by a new result, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_res) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* sv/median_of_two_sorted_lists_unit.sv */
// Median of two sorted lists: top level.
// Input channel i_in takes load and compute transactions; output channel o_out
// gives one result per compute. Loads append one signed 32-bit element to the
// first (opcode 0) or second (opcode 1) list, one per cycle while no compute is in progress.
// A load to a full list (DEPTH entries) is dropped and raises the overflow
// flag of the next result. Opcode 3 is taken and ignored.
// A compute (opcode 2) binary-searches the partition of the shorter list with
// at most log2(shorter length) + 2 probes: each probe reads two neighbors from
// each list memory through its two read ports, then compares. The result is
// valid after the setup step when both lists are empty, after a single read of
// the non-empty list when one is, and after the search otherwise; a search that
// ends with no valid partition also gives a result.
// The compute clears both lists and the overflow flag.
// The result stays in an output register until taken; loads are accepted
// meanwhile, while a further compute waits for the register to drain.
// Reset (synchronous, active low) empties both lists and clears the flag;
// the list memories themselves are not cleared, so no sweep is needed.
module median_of_two_sorted_lists_unit import mosl_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mosl_in_if.sink    i_in,
    mosl_out_if.source o_out
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_out_valid;

    // Sequencer and handshakes.
    mosl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_opcode (i_in.opcode),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    // Memories, counts, search and result registers.
    mosl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_value          (i_in.value),
        .o_median_doubled (o_out.median_doubled),
        .o_both_empty     (o_out.both_empty),
        .o_overflowed     (o_out.overflowed)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

/* dv/median_of_two_sorted_lists_unit_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for median_of_two_sorted_lists_unit.
// Streams load and compute transactions, predicts every median in the bench
// and checks each result; depends on mosl_pkg, mosl_if and the unit itself.
module median_of_two_sorted_lists_unit_test;
    import mosl_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 8;
    localparam int LIST_DEPTH     = 1024;
    localparam int RANDOM_ITEMS   = 720;
    localparam int STALL_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 100;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AT     = 12;
    localparam int QUIET_FROM     = 600;
    localparam int QUIET_TO       = 1400;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int VAL_MAX = 32'sh7fffffff;
    localparam int VAL_MIN = 32'sh80000000;

    // One pending input transaction; drain holds it back until all results are in.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        bit                       drain;
    } t_list_op;

    typedef struct packed {
        logic signed [MED_W-1:0] median_doubled;
        logic                    both_empty;
        logic                    overflowed;
    } t_median_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     drv_valid = 1'b0;
    logic [OP_W-1:0]          drv_op    = '0;
    logic signed [DATA_W-1:0] drv_value = '0;
    logic                     drv_ready = 1'b0;

    t_list_op       op_queue[$];
    t_median_result pending_medians[$];
    int             seq_first[$];
    int             seq_second[$];

    // Bench copy of the two lists and the drop flag.
    int first_mem  [LIST_DEPTH];
    int second_mem [LIST_DEPTH];
    int first_len  = 0;
    int second_len = 0;
    bit drop_seen  = 1'b0;

    int cycle_cnt     = 0;
    int in_accepted   = 0;
    int in_consumed   = 0;
    int results_seen  = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;
    int holdoff_left  = 0;
    bit holdoff_used  = 1'b0;

    mosl_in_if  in_if ();
    mosl_out_if out_if ();

    assign in_if.valid  = drv_valid;
    assign in_if.opcode = drv_op;
    assign in_if.value  = drv_value;
    assign out_if.ready = drv_ready;

    median_of_two_sorted_lists_unit #(
        .DEPTH (LIST_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Random break outside the quiet window, with a chance of about 9 in a hundred per call.
    function automatic bit take_break();
        return (cycle_cnt < QUIET_FROM || cycle_cnt >= QUIET_TO) && $urandom_range(99) < 9;
    endfunction

    function automatic int list_at(bit from_first, int idx);
        return from_first ? first_mem[idx] : second_mem[idx];
    endfunction

    // Twice the median of one non-empty list.
    function automatic longint single_twice(bit from_first, int len);
        int h;
        h = len / 2;
        if (len % 2 == 0) begin
            return longint'(list_at(from_first, h)) + longint'(list_at(from_first, h - 1));
        end
        return 2 * longint'(list_at(from_first, h));
    endfunction

    // Twice the median of two non-empty lists by partition search over the
    // shorter one; zero when no partition satisfies both cross checks.
    function automatic longint partition_twice(bit short_first, int n, int m);
        int lo, hi, half, mid, req;
        int l1, l2, r1, r2, lmax, rmin;
        bit l1v, l2v, r1v, r2v, ok1, ok2;
        lo   = 0;
        hi   = n;
        half = (n + m + 1) / 2;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            req = half - mid;
            l1v = mid > 0;
            l2v = req > 0;
            r1v = mid < n;
            r2v = req < m;
            l1  = l1v ? list_at(short_first, mid - 1) : 0;
            l2  = l2v ? list_at(!short_first, req - 1) : 0;
            r1  = r1v ? list_at(short_first, mid) : 0;
            r2  = r2v ? list_at(!short_first, req) : 0;
            ok1 = !l1v || !r2v || l1 <= r2;
            ok2 = !l2v || !r1v || l2 <= r1;
            if (ok1 && ok2) begin
                lmax = !l1v ? l2 : (!l2v ? l1 : (l1 > l2 ? l1 : l2));
                if ((n + m) % 2 == 0) begin
                    rmin = !r1v ? r2 : (!r2v ? r1 : (r1 < r2 ? r1 : r2));
                    return longint'(lmax) + longint'(rmin);
                end
                return 2 * longint'(lmax);
            end
            if (!ok1) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return 0;
    endfunction

    // Update the bench lists for one accepted transaction; a compute queues
    // its expected result and clears the lists.
    task automatic apply_list_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
        t_median_result res;
        longint         twice;
        case (op)
            OP_LOAD_FIRST: begin
                if (first_len >= LIST_DEPTH) begin
                    drop_seen = 1'b1;
                end else begin
                    first_mem[first_len] = value;
                    first_len++;
                end
            end
            OP_LOAD_SECOND: begin
                if (second_len >= LIST_DEPTH) begin
                    drop_seen = 1'b1;
                end else begin
                    second_mem[second_len] = value;
                    second_len++;
                end
            end
            OP_COMPUTE: begin
                twice          = 0;
                res.both_empty = 1'b0;
                if (first_len == 0 && second_len == 0) begin
                    res.both_empty = 1'b1;
                end else if (first_len == 0) begin
                    twice = single_twice(1'b0, second_len);
                end else if (second_len == 0) begin
                    twice = single_twice(1'b1, first_len);
                end else if (first_len > second_len) begin
                    twice = partition_twice(1'b0, second_len, first_len);
                end else begin
                    twice = partition_twice(1'b1, first_len, second_len);
                end
                res.median_doubled = twice[MED_W-1:0];
                res.overflowed     = drop_seen;
                pending_medians.push_back(res);
                first_len  = 0;
                second_len = 0;
                drop_seen  = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic add_op(logic [OP_W-1:0] op, int value, bit drain);
        t_list_op item;
        item.op    = op;
        item.value = value;
        item.drain = drain;
        op_queue.push_back(item);
    endtask

    // Fill one staging list, ascending with duplicates and clamping at the top,
    // or with arbitrary values when unordered.
    task automatic make_values(bit to_first, int len, bit ordered);
        longint cur;
        longint step;
        int     k;
        case ($urandom_range(3))
            0:       cur = VAL_MIN;
            1:       cur = int'($urandom);
            2:       cur = longint'($urandom_range(40)) - 20;
            default: cur = int'($urandom) / 256;
        endcase
        for (k = 0; k < len; k++) begin
            if (!ordered) begin
                cur = int'($urandom);
            end else if (k > 0) begin
                case ($urandom_range(7))
                    0, 1:    step = 0;
                    2, 3, 4: step = $urandom_range(1, 8);
                    5, 6:    step = $urandom_range(1, 1 << 20);
                    default: step = longint'($urandom);
                endcase
                cur = cur + step;
                if (cur > VAL_MAX) begin
                    cur = VAL_MAX;
                end
            end
            if (ordered && k == len - 1 && $urandom_range(7) == 0) begin
                cur = VAL_MAX;
            end
            if (to_first) begin
                seq_first.push_back(int'(cur));
            end else begin
                seq_second.push_back(int'(cur));
            end
        end
    endtask

    // Interleave the staged lists into loads, sprinkle ignored opcodes and end
    // with one compute.
    task automatic emit_sequence(input bit drain, output int pushed);
        bit pick_first;
        bit mark;
        pushed = 0;
        mark   = drain;
        while (seq_first.size() > 0 || seq_second.size() > 0) begin
            if ($urandom_range(99) < 4) begin
                add_op(OP_IGNORED, int'($urandom), 1'b0);
            end
            if (seq_first.size() == 0) begin
                pick_first = 1'b0;
            end else if (seq_second.size() == 0) begin
                pick_first = 1'b1;
            end else begin
                pick_first = 1'($urandom_range(1));
            end
            if (pick_first) begin
                add_op(OP_LOAD_FIRST, seq_first.pop_front(), mark);
            end else begin
                add_op(OP_LOAD_SECOND, seq_second.pop_front(), mark);
            end
            mark = 1'b0;
            pushed++;
        end
        add_op(OP_COMPUTE, int'($urandom), mark);
        pushed++;
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 12) return 0;
        if (r < 70) return $urandom_range(1, 8);
        if (r < 92) return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    // Input driver: a new transaction is offered only once the last was taken.
    always @(negedge i_clk) begin : driver
        t_list_op head;
        if (!drv_valid || in_accepted != in_consumed) begin
            in_consumed = in_accepted;
            if (i_rst_n && op_queue.size() > 0 && !take_break() &&
                !(op_queue[0].drain && pending_medians.size() > 0)) begin
                head = op_queue.pop_front();
                drv_valid <= 1'b1;
                drv_op    <= head.op;
                drv_value <= head.value;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once after a number of results.
    always @(negedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_used && results_seen >= HOLDOFF_AT) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_used <= 1'b1;
        end
    end

    // Result receiver readiness.
    always @(negedge i_clk) begin
        drv_ready <= i_rst_n && holdoff_left == 0 && !take_break();
    end

    // Monitor: check results against the oldest expectation, then predict.
    always @(posedge i_clk) begin : monitor
        t_median_result want;
        cycle_cnt++;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (pending_medians.size() == 0) begin
                    report_mismatch("result transaction with no compute waiting");
                end else begin
                    want = pending_medians.pop_front();
                    if (out_if.median_doubled !== want.median_doubled) begin
                        report_mismatch($sformatf("median_doubled %0d, expected %0d",
                            out_if.median_doubled, want.median_doubled));
                    end
                    if (out_if.both_empty !== want.both_empty) begin
                        report_mismatch($sformatf("both_empty %b, expected %b",
                            out_if.both_empty, want.both_empty));
                    end
                    if (out_if.overflowed !== want.overflowed) begin
                        report_mismatch($sformatf("overflowed %b, expected %b",
                            out_if.overflowed, want.overflowed));
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                apply_list_op(in_if.opcode, in_if.value);
                in_accepted++;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int pushed;
        int random_items;

        // Both lists empty, then the ignored opcode and a compute with a value.
        add_op(OP_COMPUTE, 0, 1'b0);
        add_op(OP_IGNORED, -1, 1'b0);
        add_op(OP_COMPUTE, -1, 1'b0);
        // One list empty: even length at the top, odd length at the bottom.
        add_op(OP_LOAD_FIRST, VAL_MAX, 1'b0);
        add_op(OP_LOAD_FIRST, VAL_MAX, 1'b0);
        add_op(OP_COMPUTE, 0, 1'b0);
        add_op(OP_LOAD_SECOND, VAL_MIN, 1'b0);
        add_op(OP_LOAD_SECOND, VAL_MIN, 1'b0);
        add_op(OP_LOAD_SECOND, VAL_MIN, 1'b0);
        add_op(OP_COMPUTE, 0, 1'b0);
        // Extremes in opposite lists, even merged length.
        add_op(OP_LOAD_FIRST, VAL_MIN, 1'b0);
        add_op(OP_LOAD_SECOND, VAL_MAX, 1'b0);
        add_op(OP_COMPUTE, 0, 1'b0);
        // Odd merged length across both lists.
        add_op(OP_LOAD_FIRST, 1, 1'b0);
        add_op(OP_LOAD_SECOND, 2, 1'b0);
        add_op(OP_LOAD_FIRST, 5, 1'b0);
        add_op(OP_LOAD_SECOND, 3, 1'b0);
        add_op(OP_LOAD_FIRST, 9, 1'b0);
        add_op(OP_COMPUTE, 0, 1'b0);
        // Unsorted lists.
        add_op(OP_LOAD_FIRST, 10, 1'b0);
        add_op(OP_LOAD_FIRST, 1, 1'b0);
        add_op(OP_LOAD_SECOND, 5, 1'b0);
        add_op(OP_LOAD_SECOND, 0, 1'b0);
        add_op(OP_COMPUTE, 0, 1'b0);

        // The first list filled past full next to a short second list, after a
        // pause for all results, then a compute that must see the drop flag
        // cleared.
        make_values(1'b1, LIST_DEPTH + 2, 1'b1);
        make_values(1'b0, 5, 1'b1);
        emit_sequence(1'b1, pushed);
        add_op(OP_COMPUTE, 0, 1'b0);

        // Random sequences, mostly sorted with random content.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            make_values(1'b1, pick_len(), $urandom_range(99) >= 6);
            make_values(1'b0, pick_len(), $urandom_range(99) >= 6);
            emit_sequence($urandom_range(99) < 5, pushed);
            random_items += pushed;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || drv_valid || pending_medians.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
